FILE: rtl/advection_rk2_central_stencil_assert.svh
// Assertion helpers shared by the stencil modules.
`ifndef ADVECTION_RK2_CENTRAL_STENCIL_ASSERT_SVH
`define ADVECTION_RK2_CENTRAL_STENCIL_ASSERT_SVH

// Condition holds at every sampled edge out of reset.
`define ADV_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("advrk2 check failed");

// Consequent holds in the same cycle as the antecedent.
`define ADV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("advrk2 check failed");

// Consequent holds in the cycle after the antecedent.
`define ADV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("advrk2 check failed");

`endif

FILE: rtl/advrk2_pkg.sv
package advrk2_pkg;

  localparam int VALUE_BITS = 24;
  localparam int DIFF_BITS  = VALUE_BITS + 1;
  localparam int K_BITS     = 16;
  localparam int PROD_BITS  = DIFF_BITS + K_BITS + 1;
  localparam int NP_BITS    = 7;
  localparam int IT_BITS    = 16;

  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_POINTS      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COURANT_NUMBER  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ITERATION_COUNT = 2'd2;

  localparam logic [NP_BITS-1:0] NUM_POINTS_RESET      = 7'd64;
  localparam logic [K_BITS-1:0]  COURANT_NUMBER_RESET  = 16'd1638;
  localparam logic [IT_BITS-1:0] ITERATION_COUNT_RESET = 16'd1;
  localparam logic [NP_BITS-1:0] MIN_POINTS            = 7'd3;

  localparam int SHIFT_ONE = 16;
  localparam int SHIFT_TWO = 15;
  localparam logic signed [PROD_BITS-1:0] ROUND_ONE = PROD_BITS'(2 ** (SHIFT_ONE - 1));
  localparam logic signed [PROD_BITS-1:0] ROUND_TWO = PROD_BITS'(2 ** (SHIFT_TWO - 1));
  localparam logic signed [PROD_BITS-1:0] SAT_HI = PROD_BITS'(2 ** (VALUE_BITS - 1) - 1);
  localparam logic signed [PROD_BITS-1:0] SAT_LO = -(PROD_BITS'(2 ** (VALUE_BITS - 1)));

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample;
    logic                         is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_value;
  } out_item_t;

  typedef struct packed {
    logic                         wr;
    logic [NP_BITS-1:0]           addr;
    logic signed [VALUE_BITS-1:0] sample;
    logic                         run;
  } cmd_t;

  typedef struct packed {
    logic [NP_BITS-1:0] points;
    logic [K_BITS-1:0]  k;
    logic [IT_BITS-1:0] iters;
  } run_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STAGE1,
    BK_STAGE2,
    BK_EMIT
  } back_state_t;

endpackage

FILE: rtl/advrk2_front.sv
module advrk2_front #(
  parameter int GRID_POINTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  advrk2_pkg::in_item_t in_data,
  output logic                 in_stall,
  input  logic                 q_full,
  output logic                 q_push,
  output advrk2_pkg::cmd_t     q_cmd
);
  import advrk2_pkg::*;

  logic [NP_BITS-1:0] load_idx_r;
  logic [NP_BITS-1:0] load_idx_nxt;
  logic               has_room;
  logic               accept;

  assign has_room = load_idx_r < NP_BITS'(GRID_POINTS);
  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign q_push   = accept;

  always_comb begin
    q_cmd.wr     = has_room;
    q_cmd.addr   = load_idx_r;
    q_cmd.sample = in_data.sample;
    q_cmd.run    = in_data.is_last;
  end

  always_comb begin
    load_idx_nxt = load_idx_r;
    if (accept) begin
      if (in_data.is_last) begin
        load_idx_nxt = '0;
      end else if (has_room) begin
        load_idx_nxt = load_idx_r + NP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
    end else begin
      load_idx_r <= load_idx_nxt;
    end
  end

endmodule

FILE: rtl/advrk2_queue.sv
`include "advection_rk2_central_stencil_assert.svh"

module advrk2_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  advrk2_pkg::cmd_t cmd_in,
  output logic             full,
  output logic             valid,
  output advrk2_pkg::cmd_t cmd_out,
  input  logic             pop
);
  import advrk2_pkg::*;

  cmd_t                 q_mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic [QCNT_BITS-1:0] cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = cnt_r == QCNT_BITS'(QUEUE_DEPTH);
  assign valid   = cnt_r != '0;
  assign cmd_out = q_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `ADV_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= QCNT_BITS'(QUEUE_DEPTH))
  `ADV_ASSERT_IMP(a_no_push_full, push, !full)
  `ADV_ASSERT_IMP(a_pop_has_data, pop, valid)
  `ADV_ASSERT_NEXT(a_cnt_grow, push && !full && !pop, cnt_r == $past(cnt_r) + QCNT_BITS'(1))

endmodule

FILE: rtl/advrk2_back.sv
`include "advection_rk2_central_stencil_assert.svh"

module advrk2_back #(
  parameter int GRID_POINTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  advrk2_pkg::run_cfg_t  cfg,
  input  logic                  q_valid,
  input  advrk2_pkg::cmd_t      q_cmd,
  output logic                  q_pop,
  output logic                  out_valid,
  output advrk2_pkg::out_item_t out_data,
  input  logic                  out_stall
);
  import advrk2_pkg::*;

  localparam int AW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;

  logic [VALUE_BITS-1:0] field_mem [GRID_POINTS];
  logic [VALUE_BITS-1:0] stage_mem [GRID_POINTS];

  back_state_t state_r;
  back_state_t state_nxt;

  logic [NP_BITS-1:0] idx_r;
  logic [NP_BITS-1:0] idx_nxt;
  logic [IT_BITS-1:0] iter_r;

  logic signed [VALUE_BITS-1:0] fs_rd_r;
  logic signed [VALUE_BITS-1:0] ss_rd_r;
  logic                         v1_r;
  logic [NP_BITS-1:0]           j1_r;
  logic                         emit_pend_r;

  logic signed [VALUE_BITS-1:0] fw0_r, fw1_r, fw2_r;
  logic signed [VALUE_BITS-1:0] sw0_r, sw1_r, sw2_r;

  logic               v2_r;
  logic [NP_BITS-1:0] c2_r;
  logic               e2_r;

  logic                         v3_r;
  logic [NP_BITS-1:0]           c3_r;
  logic signed [VALUE_BITS-1:0] u3_r;
  logic signed [DIFF_BITS-1:0]  diff_r;
  logic signed [DIFF_BITS-1:0]  diff_nxt;

  logic                         v4_r;
  logic [NP_BITS-1:0]           c4_r;
  logic signed [VALUE_BITS-1:0] u4_r;
  logic signed [PROD_BITS-1:0]  prod_r;
  logic signed [K_BITS:0]       k_s;

  logic signed [PROD_BITS-1:0] rnd_sum;
  logic signed [PROD_BITS-1:0] delta;
  logic signed [PROD_BITS-1:0] res;
  logic [VALUE_BITS-1:0]       wb_val;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic               in_stage;
  logic               is_stage1;
  logic               pipe_busy;
  logic               pass_end;
  logic               stage_issue;
  logic               emit_issue;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               load_we;
  logic               stage_we;
  logic               field_wb_we;

  assign in_stage  = (state_r == BK_STAGE1) || (state_r == BK_STAGE2);
  assign is_stage1 = state_r == BK_STAGE1;
  assign pipe_busy = v1_r || v2_r || v3_r || v4_r;
  assign pass_end  = idx_r == (cfg.points + NP_BITS'(1));
  assign rd_addr   = idx_r[AW-1:0];
  assign k_s       = {1'b0, cfg.k};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_cmd.run) begin
          state_nxt = BK_STAGE1;
        end
      end
      BK_STAGE1: begin
        if (pass_end && !pipe_busy) begin
          state_nxt = BK_STAGE2;
        end
      end
      BK_STAGE2: begin
        if (pass_end && !pipe_busy) begin
          state_nxt = (iter_r == IT_BITS'(1)) ? BK_EMIT : BK_STAGE1;
        end
      end
      BK_EMIT: begin
        if ((idx_r == cfg.points) && !emit_pend_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = (state_r == BK_IDLE) && q_valid;
    stage_issue = in_stage && (idx_r <= cfg.points);
    emit_issue  = (state_r == BK_EMIT) && (idx_r < cfg.points) && !emit_pend_r &&
                  (!out_valid_r || !out_stall);
    rd_en       = stage_issue || emit_issue;
    load_we     = q_pop && q_cmd.wr;
    stage_we    = is_stage1 && v4_r;
    field_wb_we = (state_r == BK_STAGE2) && v4_r;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (state_nxt != state_r) begin
      idx_nxt = '0;
    end else if (rd_en) begin
      idx_nxt = idx_r + NP_BITS'(1);
    end
  end

  always_comb begin
    if (e2_r) begin
      diff_nxt = '0;
    end else if (is_stage1) begin
      diff_nxt = {fw2_r[VALUE_BITS-1], fw2_r} - {fw0_r[VALUE_BITS-1], fw0_r};
    end else begin
      diff_nxt = {sw2_r[VALUE_BITS-1], sw2_r} - {sw0_r[VALUE_BITS-1], sw0_r};
    end
  end

  always_comb begin
    rnd_sum = prod_r + (is_stage1 ? ROUND_ONE : ROUND_TWO);
    delta   = is_stage1 ? (rnd_sum >>> SHIFT_ONE) : (rnd_sum >>> SHIFT_TWO);
    res     = PROD_BITS'(u4_r) - delta;
    if (res > SAT_HI) begin
      wb_val = SAT_HI[VALUE_BITS-1:0];
    end else if (res < SAT_LO) begin
      wb_val = SAT_LO[VALUE_BITS-1:0];
    end else begin
      wb_val = res[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      field_mem[q_cmd.addr[AW-1:0]] <= q_cmd.sample;
    end else if (field_wb_we) begin
      field_mem[c4_r[AW-1:0]] <= wb_val;
    end
    if (stage_we) begin
      stage_mem[c4_r[AW-1:0]] <= wb_val;
    end
    if (rd_en) begin
      fs_rd_r <= field_mem[rd_addr];
      ss_rd_r <= stage_mem[rd_addr];
      j1_r    <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      fw0_r <= fw1_r;
      fw1_r <= fw2_r;
      fw2_r <= fs_rd_r;
      sw0_r <= sw1_r;
      sw1_r <= sw2_r;
      sw2_r <= ss_rd_r;
    end
    c2_r   <= j1_r - NP_BITS'(1);
    e2_r   <= (j1_r == NP_BITS'(1)) || (j1_r == cfg.points);
    c3_r   <= c2_r;
    u3_r   <= fw1_r;
    diff_r <= diff_nxt;
    c4_r   <= c3_r;
    u4_r   <= u3_r;
    prod_r <= PROD_BITS'(diff_r) * PROD_BITS'(k_s);
    if (emit_pend_r) begin
      out_data_r.value      <= fs_rd_r;
      out_data_r.last_value <= j1_r == (cfg.points - NP_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      idx_r       <= '0;
      iter_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      emit_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      v1_r        <= stage_issue;
      v2_r        <= v1_r && (j1_r != '0);
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      emit_pend_r <= emit_issue;
      if (state_r == BK_IDLE && state_nxt == BK_STAGE1) begin
        iter_r <= cfg.iters;
      end else if (state_r == BK_STAGE2 && state_nxt == BK_STAGE1) begin
        iter_r <= iter_r - IT_BITS'(1);
      end
      if (emit_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ADV_ASSERT_IMP(a_emit_slot_free, emit_pend_r, !out_valid_r)
  `ADV_ASSERT_IMP(a_wb_in_grid, v4_r, c4_r < cfg.points)
  `ADV_ASSERT_IMP(a_emit_drained, state_r == BK_EMIT, !v2_r && !v3_r && !v4_r)

endmodule

FILE: rtl/advection_rk2_central_stencil.sv
// Linear advection on a 1-D grid, two-stage Runge-Kutta with a 3-point central difference.
// Samples load at one per cycle while in_stall is low; the sample marked is_last starts
// a run over the configured grid size. Each time step makes two passes over the grid:
// one grid point is read per cycle from each store and streams through one shared
// multiply-round-saturate pipeline of four registers, which drains before the next pass
// starts. After the run the grid is emitted one point at a time, each point read only
// once the one before it has reached the output register and the result side does not
// stall. Up to four further samples are queued during a run; after that in_stall is
// held until the run finishes. Configuration writes are taken at any time and must only
// be made while idle.
module advection_rk2_central_stencil #(
  parameter int GRID_POINTS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  advrk2_pkg::in_item_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output advrk2_pkg::out_item_t                 out_data,
  input  logic                                  cfg_we,
  input  logic [advrk2_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [advrk2_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import advrk2_pkg::*;

  logic [NP_BITS-1:0] num_points_r;
  logic [K_BITS-1:0]  courant_r;
  logic [IT_BITS-1:0] iter_count_r;
  run_cfg_t           run_cfg;

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd_in;
  cmd_t q_cmd_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r <= NUM_POINTS_RESET;
      courant_r    <= COURANT_NUMBER_RESET;
      iter_count_r <= ITERATION_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_POINTS:      num_points_r <= cfg_data[NP_BITS-1:0];
        CFG_COURANT_NUMBER:  courant_r    <= cfg_data[K_BITS-1:0];
        CFG_ITERATION_COUNT: iter_count_r <= cfg_data[IT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_points_r < MIN_POINTS) begin
      run_cfg.points = MIN_POINTS;
    end else if (num_points_r > NP_BITS'(GRID_POINTS)) begin
      run_cfg.points = NP_BITS'(GRID_POINTS);
    end else begin
      run_cfg.points = num_points_r;
    end
    run_cfg.k     = courant_r;
    run_cfg.iters = (iter_count_r == '0) ? IT_BITS'(1) : iter_count_r;
  end

  advrk2_front #(
    .GRID_POINTS(GRID_POINTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd_in)
  );

  advrk2_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (q_cmd_in),
    .full    (q_full),
    .valid   (q_valid),
    .cmd_out (q_cmd_out),
    .pop     (q_pop)
  );

  advrk2_back #(
    .GRID_POINTS(GRID_POINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (run_cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

FILE: bench/tb_advection_rk2_central_stencil.sv
`timescale 1ns / 100ps

module tb_advection_rk2_central_stencil;
  import advrk2_pkg::*;

  localparam int GRID_POINTS   = 64;
  localparam int IDLE_LIMIT    = 5_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 230;
  localparam longint VALUE_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
  localparam longint VALUE_MIN = -(64'sd1 <<< (VALUE_BITS - 1));
  localparam logic [VALUE_BITS-1:0] SAMPLE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] SAMPLE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  class advected_grid;
    logic [NP_BITS-1:0] num_points;
    logic [K_BITS-1:0]  courant;
    logic [IT_BITS-1:0] iterations;
    longint field[GRID_POINTS];
    longint stage[GRID_POINTS];
    int load_pos;
    out_item_t due_points[$];
    int errors;
    int samples;
    int runs;
    int points;

    function new();
      num_points = NUM_POINTS_RESET;
      courant    = COURANT_NUMBER_RESET;
      iterations = ITERATION_COUNT_RESET;
      load_pos   = 0;
      errors     = 0;
      samples    = 0;
      runs       = 0;
      points     = 0;
      foreach (field[i]) begin
        field[i] = 0;
        stage[i] = 0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_NUM_POINTS:      num_points = data[NP_BITS-1:0];
        CFG_COURANT_NUMBER:  courant = data[K_BITS-1:0];
        CFG_ITERATION_COUNT: iterations = data[IT_BITS-1:0];
        default: ;
      endcase
    endfunction

    // u - round(k * (hi - lo) / 2^shift), ties toward +inf, saturated
    function longint advance(longint u, longint hi, longint lo, int shift);
      longint prod;
      longint delta;
      longint r;
      prod  = (hi - lo) * longint'(courant);
      delta = (prod + (64'sd1 <<< (shift - 1))) >>> shift;
      r = u - delta;
      if (r > VALUE_MAX) r = VALUE_MAX;
      if (r < VALUE_MIN) r = VALUE_MIN;
      return r;
    endfunction

    function void take_sample(in_item_t item);
      int n;
      int steps;
      int s;
      int i;
      out_item_t point;
      samples++;
      if (load_pos < GRID_POINTS) begin
        field[load_pos] = longint'($signed(item.sample));
        load_pos++;
      end
      if (item.is_last) begin
        n = int'(num_points);
        if (n < int'(MIN_POINTS)) n = int'(MIN_POINTS);
        if (n > GRID_POINTS) n = GRID_POINTS;
        steps = (iterations == 0) ? 1 : int'(iterations);
        for (s = 0; s < steps; s++) begin
          stage[0]     = field[0];
          stage[n - 1] = field[n - 1];
          for (i = 1; i < n - 1; i++)
            stage[i] = advance(field[i], field[i + 1], field[i - 1], SHIFT_ONE);
          for (i = 1; i < n - 1; i++)
            field[i] = advance(field[i], stage[i + 1], stage[i - 1], SHIFT_TWO);
        end
        for (i = 0; i < n; i++) begin
          point.value      = field[i][VALUE_BITS-1:0];
          point.last_value = (i == n - 1);
          due_points.push_back(point);
        end
        load_pos = 0;
        runs++;
      end
    endfunction

    function void check_point(out_item_t got);
      out_item_t want;
      if (due_points.size() == 0) begin
        $error("unexpected point: value %0d last_value %0b", got.value, got.last_value);
        errors++;
        return;
      end
      want = due_points.pop_front();
      points++;
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.last_value !== want.last_value) begin
        $error("last_value: expected %0b, actual %0b", want.last_value, got.last_value);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  advected_grid grid;
  bit quiet;
  int idle_cycles = 0;

  advection_rk2_central_stencil u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 17) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3, 4: return VALUE_BITS'($urandom);
      default: return VALUE_BITS'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic send_sample(input logic [VALUE_BITS-1:0] sample, input logic last);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {sample, last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic program_run(input int np, input int k, input int it);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_POINTS;
    cfg_data  <= CFG_DATA_BITS'(np);
    @(posedge clk);
    cfg_index <= CFG_COURANT_NUMBER;
    cfg_data  <= CFG_DATA_BITS'(k);
    @(posedge clk);
    cfg_index <= CFG_ITERATION_COUNT;
    cfg_data  <= CFG_DATA_BITS'(it);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grid.due_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) grid.set_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) grid.take_sample(in_data);
      if (out_valid && !out_stall) grid.check_point(out_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no request moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      hold = quiet ? 0 : pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int filled;
    int random_items;
    int np;
    int n_pts;
    int k;
    int it;
    int loads;
    int len;
    int j;
    bit first;
    grid = new();
    quiet = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_NUM_POINTS;
    cfg_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // saturation both ways at the largest Courant number
    program_run(3, 16'hFFFF, 1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    finish_phase();

    // zero Courant number, zero iterations
    program_run(3, 0, 0);
    send_sample(24'h555555, 1'b0);
    send_sample(24'hAAAAAA, 1'b0);
    send_sample(24'h000000, 1'b1);
    finish_phase();

    // grid size below minimum, one-sample load reusing stored points
    program_run(0, 16384, 2);
    send_sample(24'hFFFFFF, 1'b1);
    finish_phase();

    // rounding ties of both signs
    program_run(7, 32768, 1);
    send_sample(24'd0, 1'b0);
    send_sample(24'd0, 1'b0);
    send_sample(24'd1, 1'b0);
    send_sample(24'd0, 1'b0);
    send_sample(24'd0, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'd0, 1'b1);
    finish_phase();

    // longest iteration count on the smallest grid
    program_run(3, 1638, 16'hFFFF);
    send_sample(24'h000100, 1'b0);
    send_sample(24'h0F0000, 1'b0);
    send_sample(24'hFFF000, 1'b1);
    finish_phase();

    filled = 7;
    random_items = 0;
    first = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4, 5, 6, 7, 8: np = $urandom_range(3, 12);
        9: np = $urandom_range(13, 64);
        10: np = ($urandom_range(0, 1) == 0) ? 64 : $urandom_range(65, 127);
        default: np = $urandom_range(0, 2);
      endcase
      case ($urandom_range(0, 9))
        0: k = 0;
        1: k = 16'hFFFF;
        2, 3, 4, 5: k = $urandom_range(0, 8192);
        default: k = $urandom_range(0, 16'hFFFF);
      endcase
      case ($urandom_range(0, 9))
        0: it = 0;
        7, 8: it = $urandom_range(3, 4);
        9: it = $urandom_range(5, 8);
        default: it = $urandom_range(1, 2);
      endcase
      if (first) np = 127;
      program_run(np, k, it);
      n_pts = (np < 3) ? 3 : ((np > GRID_POINTS) ? GRID_POINTS : np);
      quiet = ($urandom_range(0, 3) == 0);
      loads = first ? 1 : $urandom_range(1, 3);
      repeat (loads) begin
        case ($urandom_range(0, 9))
          6, 7: len = $urandom_range(1, n_pts);
          8: len = n_pts + $urandom_range(1, 4);
          9: len = $urandom_range(1, 3);
          default: len = n_pts;
        endcase
        // overflow the store on the first load
        if (first) len = GRID_POINTS + 2;
        if (filled < n_pts && len < n_pts) len = n_pts;
        for (j = 0; j < len; j++)
          send_sample(random_sample(), j == len - 1);
        if (len > filled) filled = (len > GRID_POINTS) ? GRID_POINTS : len;
        random_items += len;
      end
      first = 1'b0;
      finish_phase();
    end
    quiet = 1'b0;

    $display("%0d runs from %0d samples, %0d grid points checked", grid.runs, grid.samples,
             grid.points);
    $display("grid sizes clamped low and high, load overflow, Courant 0 to max, 0 to 65535 steps");
    if (grid.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
